/* hdl/utc_pkg.sv */
// ----------------------------------------------------------------------------
// UUID text codec package
// Shared types, character codes and position helpers for the UUID text codec.
// ----------------------------------------------------------------------------
`default_nettype none

package utc_pkg;

    // Command codes
    localparam logic [1:0] CMD_PARSE    = 2'd0;
    localparam logic [1:0] CMD_EMIT_RFC = 2'd1;
    localparam logic [1:0] CMD_EMIT_HEX = 2'd2;

    // Result status codes
    localparam logic [1:0] STATUS_ACCEPTED = 2'd0;
    localparam logic [1:0] STATUS_IGNORED  = 2'd1;
    localparam logic [1:0] STATUS_ZEROED   = 2'd2;
    localparam logic [1:0] STATUS_TEXT     = 2'd3;

    // ASCII codes
    localparam logic [7:0] CHAR_0      = 8'h30;
    localparam logic [7:0] CHAR_9      = 8'h39;
    localparam logic [7:0] CHAR_LA     = 8'h61;
    localparam logic [7:0] CHAR_LF     = 8'h66;
    localparam logic [7:0] CHAR_UA     = 8'h41;
    localparam logic [7:0] CHAR_UF     = 8'h46;
    localparam logic [7:0] CHAR_DASH   = 8'h2D;
    localparam logic [7:0] CHAR_LBRACE = 8'h7B;
    localparam logic [7:0] CHAR_RBRACE = 8'h7D;
    localparam logic [7:0] CHAR_NONE   = 8'h00;

    // Text lengths, count limit and positions in the braced and plain forms
    localparam logic [5:0] BRACED_LEN = 6'd38;
    localparam logic [5:0] PLAIN_LEN  = 6'd32;
    localparam logic [5:0] COUNT_MAX  = 6'd63;
    localparam logic [5:0] POS_OPEN   = 6'd0;
    localparam logic [5:0] POS_DASH0  = 6'd9;
    localparam logic [5:0] POS_DASH1  = 6'd14;
    localparam logic [5:0] POS_DASH2  = 6'd19;
    localparam logic [5:0] POS_DASH3  = 6'd24;
    localparam logic [5:0] POS_CLOSE  = 6'd37;
    localparam logic [5:0] POS_LAST_HEX = 6'd31;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] char_in;
        logic       last_in;
    } utc_in_t;

    typedef struct packed {
        logic [7:0]  char_out;
        logic [63:0] uuid_high;
        logic [63:0] uuid_low;
        logic [1:0]  status;
        logic        nonzero;
        logic        last_out;
    } utc_out_t;

    // Request to and response from the shared hex conversion unit
    typedef struct packed {
        logic [7:0] dec_char;
        logic [3:0] enc_nibble;
        logic       upper;
    } hex_req_t;

    typedef struct packed {
        logic [3:0] dec_value;
        logic       dec_bad;
        logic [7:0] enc_char;
    } hex_rsp_t;

    typedef struct packed {
        logic       valid;
        logic [4:0] idx;
    } digit_sel_t;

    // Maps a braced-form position to its hex digit index; delimiters give no digit.
    function automatic digit_sel_t braced_digit(input logic [5:0] p);
        digit_sel_t sel;
        logic [5:0] d;
        d = 6'd0;
        sel.valid = 1'b1;
        if (p >= 6'd1 && p <= 6'd8) begin
            d = p - 6'd1;
        end else if (p >= 6'd10 && p <= 6'd13) begin
            d = p - 6'd2;
        end else if (p >= 6'd15 && p <= 6'd18) begin
            d = p - 6'd3;
        end else if (p >= 6'd20 && p <= 6'd23) begin
            d = p - 6'd4;
        end else if (p >= 6'd25 && p <= 6'd36) begin
            d = p - 6'd5;
        end else begin
            sel.valid = 1'b0;
        end
        sel.idx = d[4:0];
        return sel;
    endfunction

endpackage

`default_nettype wire

/* hdl/utc_hex_unit.sv */
// ----------------------------------------------------------------------------
// UUID text codec hex unit
// Shared converter between ASCII hex characters and 4-bit nibble values.
// ----------------------------------------------------------------------------
`default_nettype none

module utc_hex_unit (
    input  wire utc_pkg::hex_req_t req,
    output utc_pkg::hex_rsp_t      rsp
);
    import utc_pkg::*;

    logic [7:0] dec_diff;
    logic [7:0] enc_base;

    always_comb
    begin
        dec_diff    = 8'd0;
        rsp.dec_bad = 1'b0;
        case (req.dec_char) inside
            [CHAR_0:CHAR_9]:
            begin
                dec_diff = req.dec_char - CHAR_0;
            end
            [CHAR_LA:CHAR_LF]:
            begin
                dec_diff = req.dec_char - CHAR_LA + 8'd10;
            end
            [CHAR_UA:CHAR_UF]:
            begin
                dec_diff = req.dec_char - CHAR_UA + 8'd10;
            end
            default:
            begin
                rsp.dec_bad = 1'b1;
            end
        endcase
        rsp.dec_value = dec_diff[3:0];

        enc_base = req.upper ? CHAR_UA : CHAR_LA;
        if (req.enc_nibble < 4'd10) begin
            rsp.enc_char = CHAR_0 + {4'd0, req.enc_nibble};
        end else begin
            rsp.enc_char = enc_base + {4'd0, req.enc_nibble} - 8'd10;
        end
    end

endmodule

`default_nettype wire

/* hdl/uuid_text_codec_core.sv */
// ----------------------------------------------------------------------------
// UUID text codec core
// Parses UUID text one character per transfer and emits the stored UUID as text.
// Parse: one character per cycle; a final character's result appears in the
// cycle after it. Emit: 38 (braced) or 32 (plain) results via the shared hex
// unit, one per cycle; input resumes after the last one. Output stalls hold both.
// Reset clears the stored UUID, parse progress and the letter-case register.
// ----------------------------------------------------------------------------
`default_nettype none

module uuid_text_codec_core (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    output logic                  in_ready,
    input  wire utc_pkg::utc_in_t in_data,
    output logic                  out_valid,
    input  wire                   out_ready,
    output utc_pkg::utc_out_t     out_data,
    input  wire                   cfg_valid,
    output logic                  cfg_ready,
    input  wire                   cfg_data
);
    import utc_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic       state_reg, state_next;
    logic       emit_braced_reg, emit_braced_next;
    logic [5:0] emit_idx_reg, emit_idx_next;
    logic       upper_reg;

    logic [7:0] stored_reg [16];
    logic [7:0] stored_next [16];
    logic [7:0] incoming_reg [16];
    logic [7:0] incoming_next [16];

    logic [5:0] char_count_reg, char_count_next;
    logic       brace_form_reg, brace_form_next;
    logic       delim_ok_reg, delim_ok_next;
    logic       digits_ok_reg, digits_ok_next;
    logic [3:0] high_nibble_reg, high_nibble_next;

    logic     out_valid_reg, out_valid_next;
    utc_out_t out_data_reg, out_data_next;

    hex_req_t   hex_req;
    hex_rsp_t   hex_rsp;
    logic       in_fire;
    logic       out_slot;
    logic       load_out;
    logic [5:0] p;
    logic       brace_now;
    digit_sel_t parse_sel;
    digit_sel_t emit_sel;
    logic [3:0] digit_val;
    logic [5:0] count_inc;
    logic       length_ok;
    logic [1:0] parse_status;
    logic [7:0] emit_byte;
    logic       emit_last;
    logic [7:0] emit_char;
    logic       any_nonzero;

    utc_hex_unit u_hex (
        .req(hex_req),
        .rsp(hex_rsp)
    );

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        out_slot = !out_valid_reg || out_ready;
        in_ready = (state_reg == ST_IDLE) && out_slot;
        in_fire  = in_valid && in_ready;

        // Parse position decode
        p         = char_count_reg;
        brace_now = brace_form_reg || (p == 6'd0 && in_data.char_in == CHAR_LBRACE);
        parse_sel = '0;
        if (brace_now) begin
            if (p != POS_DASH0 && p != POS_DASH1 && p != POS_DASH2 && p != POS_DASH3
                && p != POS_CLOSE && p != POS_OPEN) begin
                parse_sel = braced_digit(p);
            end
        end else if (p < PLAIN_LEN) begin
            parse_sel.valid = 1'b1;
            parse_sel.idx   = p[4:0];
        end

        // Emit position decode
        if (emit_braced_reg) begin
            emit_sel = braced_digit(emit_idx_reg);
        end else begin
            emit_sel.valid = 1'b1;
            emit_sel.idx   = emit_idx_reg[4:0];
        end
        emit_byte = stored_reg[emit_sel.idx[4:1]];

        hex_req.dec_char   = in_data.char_in;
        hex_req.enc_nibble = emit_sel.idx[0] ? emit_byte[3:0] : emit_byte[7:4];
        hex_req.upper      = upper_reg;

        digit_val = hex_rsp.dec_bad ? 4'd0 : hex_rsp.dec_value;
        count_inc = (p < COUNT_MAX) ? p + 6'd1 : p;

        if (emit_braced_reg) begin
            emit_last = (emit_idx_reg == POS_CLOSE);
            case (emit_idx_reg)
                POS_OPEN:  emit_char = CHAR_LBRACE;
                POS_CLOSE: emit_char = CHAR_RBRACE;
                POS_DASH0, POS_DASH1, POS_DASH2, POS_DASH3: emit_char = CHAR_DASH;
                default:   emit_char = hex_rsp.enc_char;
            endcase
        end else begin
            emit_last = (emit_idx_reg == POS_LAST_HEX);
            emit_char = hex_rsp.enc_char;
        end

        // Defaults
        state_next       = state_reg;
        emit_braced_next = emit_braced_reg;
        emit_idx_next    = emit_idx_reg;
        char_count_next  = char_count_reg;
        brace_form_next  = brace_form_reg;
        delim_ok_next    = delim_ok_reg;
        digits_ok_next   = digits_ok_reg;
        high_nibble_next = high_nibble_reg;
        stored_next      = stored_reg;
        incoming_next    = incoming_reg;
        load_out         = 1'b0;
        length_ok        = 1'b0;
        parse_status     = STATUS_ACCEPTED;
        out_data_next    = out_data_reg;

        if (in_fire && in_data.cmd == CMD_PARSE) begin
            brace_form_next = brace_now;
            if (brace_now) begin
                if ((p == POS_DASH0 || p == POS_DASH1 || p == POS_DASH2 || p == POS_DASH3)
                    && in_data.char_in != CHAR_DASH) begin
                    delim_ok_next = 1'b0;
                end
                if (p == POS_CLOSE && in_data.char_in != CHAR_RBRACE) begin
                    delim_ok_next = 1'b0;
                end
            end
            if (parse_sel.valid) begin
                if (hex_rsp.dec_bad) begin
                    digits_ok_next = 1'b0;
                end
                if (!parse_sel.idx[0]) begin
                    high_nibble_next = digit_val;
                end else begin
                    incoming_next[parse_sel.idx[4:1]] = {high_nibble_reg, digit_val};
                end
            end
            char_count_next = count_inc;

            if (in_data.last_in) begin
                length_ok = brace_now ? (count_inc == BRACED_LEN) : (count_inc == PLAIN_LEN);
                if (!length_ok || !delim_ok_next) begin
                    parse_status = STATUS_IGNORED;
                end else if (!digits_ok_next) begin
                    parse_status = STATUS_ZEROED;
                    for (int i = 0; i < 16; i++) begin
                        stored_next[i] = 8'd0;
                    end
                end else begin
                    parse_status = STATUS_ACCEPTED;
                    stored_next  = incoming_next;
                end
                // The text is finished, so parse progress starts over.
                char_count_next  = 6'd0;
                brace_form_next  = 1'b0;
                delim_ok_next    = 1'b1;
                digits_ok_next   = 1'b1;
                high_nibble_next = 4'd0;
                load_out                = 1'b1;
                out_data_next.char_out  = CHAR_NONE;
                out_data_next.status    = parse_status;
                out_data_next.last_out  = 1'b1;
            end
        end else if (in_fire && in_data.cmd == CMD_EMIT_RFC) begin
            state_next       = ST_EMIT;
            emit_braced_next = 1'b1;
            emit_idx_next    = 6'd0;
        end else if (in_fire && in_data.cmd == CMD_EMIT_HEX) begin
            state_next       = ST_EMIT;
            emit_braced_next = 1'b0;
            emit_idx_next    = 6'd0;
        end

        if (state_reg == ST_EMIT && out_slot) begin
            load_out               = 1'b1;
            out_data_next.char_out = emit_char;
            out_data_next.status   = STATUS_TEXT;
            out_data_next.last_out = emit_last;
            if (emit_last) begin
                state_next = ST_IDLE;
            end else begin
                emit_idx_next = emit_idx_reg + 6'd1;
            end
        end

        any_nonzero = 1'b0;
        for (int i = 0; i < 8; i++) begin
            out_data_next.uuid_high[63 - 8 * i -: 8] = stored_next[i];
            out_data_next.uuid_low[63 - 8 * i -: 8]  = stored_next[i + 8];
        end
        for (int i = 0; i < 16; i++) begin
            any_nonzero = any_nonzero || (stored_next[i] != 8'd0);
        end
        out_data_next.nonzero = any_nonzero;
        if (!load_out) begin
            out_data_next = out_data_reg;
        end

        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg       <= ST_IDLE;
            emit_braced_reg <= 1'b0;
            emit_idx_reg    <= 6'd0;
            upper_reg       <= 1'b0;
            char_count_reg  <= 6'd0;
            brace_form_reg  <= 1'b0;
            delim_ok_reg    <= 1'b1;
            digits_ok_reg   <= 1'b1;
            high_nibble_reg <= 4'd0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < 16; i++) begin
                stored_reg[i] <= 8'd0;
            end
        end else begin
            state_reg       <= state_next;
            emit_braced_reg <= emit_braced_next;
            emit_idx_reg    <= emit_idx_next;
            if (cfg_valid && cfg_ready) begin
                upper_reg <= cfg_data;
            end
            char_count_reg  <= char_count_next;
            brace_form_reg  <= brace_form_next;
            delim_ok_reg    <= delim_ok_next;
            digits_ok_reg   <= digits_ok_next;
            high_nibble_reg <= high_nibble_next;
            out_valid_reg   <= out_valid_next;
            stored_reg      <= stored_next;
        end
    end

    always_ff @(posedge clk)
    begin
        incoming_reg <= incoming_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

/* verif/tb_uuid_text_codec_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UUID text codec core testbench
// Sends parse and emit commands through the valid/ready channels with random
// gaps on both sides in all but one phase. A behavioral copy of the codec
// works out every result; each returned result is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_uuid_text_codec_core;
    import utc_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 40;
    localparam int PHASE_ITEMS   = 16;

    // The fourth command code has no function in the block.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef enum int {
        FLAW_NONE,
        FLAW_BAD_HEX,
        FLAW_BAD_DELIM,
        FLAW_SHORT,
        FLAW_LONG
    } text_flaw_t;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_ready;
    utc_in_t  in_data   = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    utc_out_t out_data;
    logic     cfg_valid = 1'b0;
    logic     cfg_ready;
    logic     cfg_data  = 1'b0;

    utc_in_t  pending_items[$];
    utc_out_t due_results[$];

    int in_idle_pct  = 25;
    int out_idle_pct = 25;
    int mismatches   = 0;
    int items_queued = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int cycle_count  = 0;
    int text_outcomes[0:3] = '{default: 0};

    // Behavioral copy of the codec state.
    logic [7:0] id_bytes[16];
    logic [7:0] rx_bytes[16];
    logic [5:0] rx_count;
    logic       rx_braced;
    logic       rx_delims_ok;
    logic       rx_digits_ok;
    logic [3:0] rx_hi;
    logic       case_upper;

    uuid_text_codec_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #(CLK_HALF) clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Codec model
    // ------------------------------------------------------------------
    function automatic int hex_val(logic [7:0] c);
        if (c >= CHAR_0 && c <= CHAR_9) return int'(c - CHAR_0);
        if (c >= CHAR_LA && c <= CHAR_LF) return int'(c - CHAR_LA) + 10;
        if (c >= CHAR_UA && c <= CHAR_UF) return int'(c - CHAR_UA) + 10;
        return -1;
    endfunction

    function automatic logic [7:0] hex_glyph(logic [3:0] n);
        logic [7:0] w;
        w = {4'd0, n};
        if (w < 8'd10) return CHAR_0 + w;
        return (case_upper ? CHAR_UA : CHAR_LA) + w - 8'd10;
    endfunction

    function automatic bit is_dash_pos(int p);
        return p == POS_DASH0 || p == POS_DASH1 || p == POS_DASH2 || p == POS_DASH3;
    endfunction

    // Digit index of a braced-form position: skip the brace and every dash before it.
    function automatic int rfc_digit(int p);
        if (p <= POS_OPEN || p >= POS_CLOSE || is_dash_pos(p)) return -1;
        return p - 1 - int'(p > POS_DASH0) - int'(p > POS_DASH1)
                     - int'(p > POS_DASH2) - int'(p > POS_DASH3);
    endfunction

    function automatic logic [3:0] nibble_of(int d);
        logic [7:0] b;
        b = id_bytes[d / 2];
        return (d % 2 == 1) ? b[3:0] : b[7:4];
    endfunction

    function automatic utc_out_t snapshot(logic [7:0] ch, logic [1:0] st, logic fin);
        utc_out_t   r;
        logic [127:0] id;
        for (int i = 0; i < 16; i++) id[127 - 8 * i -: 8] = id_bytes[i];
        r.char_out  = ch;
        r.uuid_high = id[127:64];
        r.uuid_low  = id[63:0];
        r.status    = st;
        r.nonzero   = |id;
        r.last_out  = fin;
        return r;
    endfunction

    task automatic clear_parse_progress();
        rx_count     = '0;
        rx_braced    = 1'b0;
        rx_delims_ok = 1'b1;
        rx_digits_ok = 1'b1;
        rx_hi        = '0;
    endtask

    task automatic rx_take(int d, logic [7:0] c);
        int v;
        if (d < 0 || d > 31) return;
        v = hex_val(c);
        if (v < 0)
        begin
            rx_digits_ok = 1'b0;
            v = 0;
        end
        if (d % 2 == 0) rx_hi = v[3:0];
        else rx_bytes[d / 2] = {rx_hi, v[3:0]};
    endtask

    task automatic compute_codec_results(utc_in_t item);
        int         p;
        logic       fits;
        logic [1:0] st;
        logic [7:0] ch;
        p = int'(rx_count);
        case (item.cmd)
            CMD_PARSE:
            begin
                if (p == POS_OPEN && item.char_in == CHAR_LBRACE) rx_braced = 1'b1;
                if (rx_braced)
                begin
                    if (is_dash_pos(p))
                    begin
                        if (item.char_in != CHAR_DASH) rx_delims_ok = 1'b0;
                    end
                    else if (p == POS_CLOSE)
                    begin
                        if (item.char_in != CHAR_RBRACE) rx_delims_ok = 1'b0;
                    end
                    else if (p != POS_OPEN)
                    begin
                        rx_take(rfc_digit(p), item.char_in);
                    end
                end
                else if (p < PLAIN_LEN)
                begin
                    rx_take(p, item.char_in);
                end
                if (rx_count != COUNT_MAX) rx_count = rx_count + 6'd1;
                if (item.last_in)
                begin
                    fits = rx_braced ? (rx_count == BRACED_LEN) : (rx_count == PLAIN_LEN);
                    // Length and delimiter faults win over a bad digit.
                    if (!fits || !rx_delims_ok)
                    begin
                        st = STATUS_IGNORED;
                    end
                    else if (!rx_digits_ok)
                    begin
                        st = STATUS_ZEROED;
                        id_bytes = '{default: 8'h00};
                    end
                    else
                    begin
                        st = STATUS_ACCEPTED;
                        id_bytes = rx_bytes;
                    end
                    clear_parse_progress();
                    text_outcomes[st]++;
                    due_results.push_back(snapshot(CHAR_NONE, st, 1'b1));
                end
            end
            CMD_EMIT_RFC:
            begin
                for (int k = 0; k < BRACED_LEN; k++)
                begin
                    if (k == POS_OPEN) ch = CHAR_LBRACE;
                    else if (k == POS_CLOSE) ch = CHAR_RBRACE;
                    else if (is_dash_pos(k)) ch = CHAR_DASH;
                    else ch = hex_glyph(nibble_of(rfc_digit(k)));
                    due_results.push_back(snapshot(ch, STATUS_TEXT, k == POS_CLOSE));
                end
            end
            CMD_EMIT_HEX:
            begin
                for (int k = 0; k < PLAIN_LEN; k++)
                    due_results.push_back(snapshot(hex_glyph(nibble_of(k)), STATUS_TEXT,
                                                   k == POS_LAST_HEX));
            end
            default:
            begin
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic note_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("tb_uuid_text_codec_core: result %0d %s: got %h, expected %h",
                 results_seen, what, got, want);
        mismatches++;
    endtask

    task automatic check_result(utc_out_t got);
        utc_out_t want;
        results_seen++;
        if (due_results.size() == 0)
        begin
            note_mismatch("arrived with nothing expected", got.char_out, '0);
            return;
        end
        want = due_results.pop_front();
        if (got.char_out != want.char_out) note_mismatch("char_out", got.char_out, want.char_out);
        if (got.uuid_high != want.uuid_high)
            note_mismatch("uuid_high", got.uuid_high, want.uuid_high);
        if (got.uuid_low != want.uuid_low) note_mismatch("uuid_low", got.uuid_low, want.uuid_low);
        if (got.status != want.status) note_mismatch("status", got.status, want.status);
        if (got.nonzero != want.nonzero) note_mismatch("nonzero", got.nonzero, want.nonzero);
        if (got.last_out != want.last_out) note_mismatch("last_out", got.last_out, want.last_out);
    endtask

    // ------------------------------------------------------------------
    // Driver, monitor and watchdog
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                compute_codec_results(in_data);
                items_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_items.size() > 0 && $urandom_range(0, 99) >= in_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data  <= pending_items.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready) check_result(out_data);
            out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_uuid_text_codec_core: timeout after %0d cycles", cycle_count);
            $display("tb_uuid_text_codec_core: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic queue_item(logic [1:0] cmd, logic [7:0] c, logic fin);
        utc_in_t it;
        it.cmd     = cmd;
        it.char_in = c;
        it.last_in = fin;
        pending_items.push_back(it);
        items_queued++;
    endtask

    task automatic queue_text(string s, logic closes);
        for (int i = 0; i < s.len(); i++)
            queue_item(CMD_PARSE, s[i], closes && i == s.len() - 1);
    endtask

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] rand_hex_glyph();
        logic [7:0] v;
        v = 8'($urandom_range(0, 15));
        if (v < 8'd10) return CHAR_0 + v;
        return ($urandom_range(0, 1) ? CHAR_UA : CHAR_LA) + v - 8'd10;
    endfunction

    function automatic logic [7:0] rand_non_hex();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (hex_val(c) >= 0);
        return c;
    endfunction

    // Sends a text; now and then an emit or an unused command lands mid-text.
    task automatic queue_chars(logic [7:0] txt[$]);
        int cut;
        cut = ($urandom_range(0, 99) < 15) ? $urandom_range(1, txt.size()) : -1;
        foreach (txt[i])
        begin
            if (i == cut) queue_item(2'($urandom_range(1, 3)), rand_byte(), $urandom_range(0, 1));
            queue_item(CMD_PARSE, txt[i], i == txt.size() - 1);
        end
    endtask

    task automatic queue_uuid_text(logic braced, text_flaw_t flaw);
        logic [7:0] txt[$];
        logic [7:0] c;
        int         k;
        int         n;
        for (int p = 0; p < (braced ? BRACED_LEN : PLAIN_LEN); p++)
        begin
            if (!braced) txt.push_back(rand_hex_glyph());
            else if (p == POS_OPEN) txt.push_back(CHAR_LBRACE);
            else if (p == POS_CLOSE) txt.push_back(CHAR_RBRACE);
            else if (is_dash_pos(p)) txt.push_back(CHAR_DASH);
            else txt.push_back(rand_hex_glyph());
        end
        case (flaw)
            FLAW_BAD_HEX:
            begin
                do k = $urandom_range(0, txt.size() - 1); while (braced && rfc_digit(k) < 0);
                txt[k] = rand_non_hex();
            end
            FLAW_BAD_DELIM:
            begin
                if (braced)
                begin
                    case ($urandom_range(0, 4))
                        0: k = POS_DASH0;
                        1: k = POS_DASH1;
                        2: k = POS_DASH2;
                        3: k = POS_DASH3;
                        default: k = POS_CLOSE;
                    endcase
                    do c = 8'($urandom_range(1, 255)); while (c == txt[k]);
                    txt[k] = c;
                end
                else
                begin
                    // A dash in the plain form is just a bad digit.
                    txt[$urandom_range(0, PLAIN_LEN - 1)] = CHAR_DASH;
                end
            end
            FLAW_SHORT:
            begin
                n = $urandom_range(1, txt.size() - 1);
                while (txt.size() > n) void'(txt.pop_back());
            end
            FLAW_LONG:
            begin
                n = $urandom_range(1, 30);
                repeat (n) txt.push_back(rand_hex_glyph());
            end
            default:
            begin
            end
        endcase
        queue_chars(txt);
    endtask

    task automatic queue_garbage_text();
        logic [7:0] txt[$];
        repeat ($urandom_range(1, 6)) txt.push_back(8'($urandom_range(1, 255)));
        queue_chars(txt);
    endtask

    // Mostly well-formed texts with random digits, plus emits and noise.
    task automatic queue_random_phase(int count);
        int stop;
        int pick;
        stop = items_queued + count;
        while (items_queued < stop)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35) queue_uuid_text($urandom_range(0, 1), FLAW_NONE);
            else if (pick < 50)
                queue_uuid_text($urandom_range(0, 1), text_flaw_t'($urandom_range(1, 4)));
            else if (pick < 65) queue_item(CMD_EMIT_RFC, rand_byte(), $urandom_range(0, 1));
            else if (pick < 80) queue_item(CMD_EMIT_HEX, rand_byte(), $urandom_range(0, 1));
            else if (pick < 90) queue_item(CMD_UNUSED, rand_byte(), $urandom_range(0, 1));
            else queue_garbage_text();
        end
    endtask

    task automatic wait_for_drain();
        do @(negedge clk);
        while (pending_items.size() != 0 || in_valid || due_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_letter_case(logic upper);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= upper;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case_upper = upper;
        @(negedge clk);
    endtask

    initial
    begin
        id_bytes   = '{default: 8'h00};
        rx_bytes   = '{default: 8'h00};
        case_upper = 1'b0;
        clear_parse_progress();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        write_letter_case(1'b0);

        // Directed texts: reset value, a NUL character as a bad digit, emits in
        // the middle of a text, each rejection reason and the saturating count.
        queue_item(CMD_EMIT_RFC, 8'h00, 1'b0);
        queue_item(CMD_EMIT_HEX, 8'hFF, 1'b1);
        queue_text("0123456789abcdef0123456789abcde", 1'b0);
        queue_item(CMD_PARSE, CHAR_NONE, 1'b1);
        queue_text("{0123abcd-", 1'b0);
        queue_item(CMD_EMIT_RFC, 8'hAA, 1'b1);
        queue_item(CMD_UNUSED, 8'hFF, 1'b1);
        queue_text("EF45-6789-AbCd-0123456789aB}", 1'b1);
        queue_item(CMD_EMIT_HEX, 8'h55, 1'b0);
        queue_text("{0123abcd-ef45+6789-abcd-0123456789ab}", 1'b1);
        queue_text("{", 1'b1);
        repeat (63) queue_item(CMD_PARSE, rand_hex_glyph(), 1'b0);
        queue_item(CMD_PARSE, CHAR_0, 1'b1);
        queue_item(CMD_PARSE, 8'hFF, 1'b0);
        queue_item(CMD_PARSE, 8'h80, 1'b1);
        wait_for_drain();

        write_letter_case(1'b1);
        queue_item(CMD_EMIT_RFC, 8'h01, 1'b0);
        queue_item(CMD_EMIT_HEX, 8'hFE, 1'b1);

        // The sender holds off halfway until every result is back.
        queue_random_phase(PHASE_ITEMS / 2);
        wait_for_drain();
        queue_random_phase(PHASE_ITEMS / 2);
        wait_for_drain();

        write_letter_case(1'b0);
        in_idle_pct  = 0;
        out_idle_pct = 0;
        queue_random_phase(PHASE_ITEMS);
        wait_for_drain();

        in_idle_pct  = 25;
        out_idle_pct = 25;
        write_letter_case(1'b1);
        queue_random_phase(PHASE_ITEMS);
        wait_for_drain();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("tb_uuid_text_codec_core: %0d commands sent, %0d results checked, %0d mismatches",
                 items_sent, results_seen, mismatches);
        $display("tb_uuid_text_codec_core: texts accepted %0d, ignored %0d, zeroed %0d, both cases",
                 text_outcomes[STATUS_ACCEPTED], text_outcomes[STATUS_IGNORED],
                 text_outcomes[STATUS_ZEROED]);
        if (mismatches == 0)
            $display("tb_uuid_text_codec_core: PASS");
        else
            $display("tb_uuid_text_codec_core: FAIL");
        $finish;
    end

endmodule
